// ----- rtl/core/bms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bms_pkg
// shared types, character codes and status codes of the bracket match scanner
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int OFFSET_W = 24;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 3;

    localparam logic [OFFSET_W-1:0] COUNT_MAX = {OFFSET_W{1'b1}};

    // closer codes held on the stack
    localparam logic [1:0] CODE_NONE    = 2'd0;
    localparam logic [1:0] CODE_BRACE   = 2'd1;
    localparam logic [1:0] CODE_PAREN   = 2'd2;
    localparam logic [1:0] CODE_BRACKET = 2'd3;

    // scan status codes
    localparam logic [STATUS_W-1:0] ST_SCANNING = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MATCHED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    // character codes
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;

    // classified byte handed from front to back
    typedef struct packed {
        logic                start;
        logic [1:0]          push;
        logic [1:0]          close;
        logic                eob;
        logic [OFFSET_W-1:0] here;
    } t_item;

    // queue status seen by the input handshake and the back end
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

    function automatic logic [1:0] push_code(input logic [7:0] ch);
        logic [1:0] c;
        case (ch)
            CH_LBRACE:   c = CODE_BRACE;
            CH_LPAREN:   c = CODE_PAREN;
            CH_LBRACKET: c = CODE_BRACKET;
            default:     c = CODE_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] close_code(input logic [7:0] ch);
        logic [1:0] c;
        case (ch)
            CH_RBRACE:   c = CODE_BRACE;
            CH_RPAREN:   c = CODE_PAREN;
            CH_RBRACKET: c = CODE_BRACKET;
            default:     c = CODE_NONE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bracket_match_scanner.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_match_scanner
// forward scan for the closer matching a bracket, with quote/comment skipping
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_ready    start_scan, text_byte, end_of_buffer
//  out       source     o_out_valid / i_out_ready  scan_status, match_offset, nesting_depth
//  cfg       sink       i_cfg_valid / o_cfg_ready  skip_quotes_comments
//
//  one beat per cycle unless the output stalls; each result is registered after a queue slot
//  rate is set by the single stack push or pop per cycle in the back end
//  the stack top lives in a register, the rest in a ram with a one-cycle prefetch
//  reset is synchronous, active low; no clearing pass, stack entries are read only
//  after being pushed
//  either side may stall: a two-entry queue parts front and back, and a result
//  register holds the output beat until taken
// ----------------------------------------------------------------------------
module bracket_match_scanner
    import bms_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input beats
    input  wire logic                i_in_valid,
    output      logic                o_in_ready,
    input  wire logic                i_start_scan,
    input  wire logic [7:0]          i_text_byte,
    input  wire logic                i_end_of_buffer,
    // result beats
    output      logic                o_out_valid,
    input  wire logic                i_out_ready,
    output      logic [STATUS_W-1:0] o_scan_status,
    output      logic [OFFSET_W-1:0] o_match_offset,
    output      logic [DEPTH_W-1:0]  o_nesting_depth,
    // configuration beats
    input  wire logic                i_cfg_valid,
    output      logic                o_cfg_ready,
    input  wire logic                i_cfg_data
);

    // depth at which the scan stops with overflow
    localparam int DEPTH_LIMIT = (STACK_DEPTH - 1 < 127) ? STACK_DEPTH - 1 : 127;

    logic      r_skip_qc;
    logic      in_beat;
    logic      pop;
    t_item     front_item;
    t_item     head_item;
    t_q_status q_status;

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_qc <= 1'b1;
        end else if (i_cfg_valid) begin
            r_skip_qc <= i_cfg_data;
        end
    end

    // front takes a beat whenever the queue has room
    assign o_in_ready = !q_status.full;
    assign in_beat    = i_in_valid && o_in_ready;

    bms_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_beat          (in_beat),
        .i_skip_qc       (r_skip_qc),
        .i_start_scan    (i_start_scan),
        .i_text_byte     (i_text_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_item          (front_item)
    );

    bms_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_beat),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    bms_back #(
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (q_status),
        .i_item          (head_item),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_scan_status   (o_scan_status),
        .o_match_offset  (o_match_offset),
        .o_nesting_depth (o_nesting_depth)
    );

    // a match always leaves the stack empty
    a_match_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scan_status == ST_MATCHED) |-> (o_nesting_depth == '0))
        else $error("match reported with brackets still open");

    // offset is only carried by match and mismatch
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scan_status != ST_MATCHED && o_scan_status != ST_MISMATCH)
        |-> (o_match_offset == '0))
        else $error("offset set on a status that carries none");

    // an accepted input beat is waiting in the queue on the next cycle
    a_beat_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> q_status.valid)
        else $error("accepted input beat lost before the back end");

    // depth never passes the overflow limit
    a_depth_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (o_nesting_depth <= DEPTH_W'(DEPTH_LIMIT)))
        else $error("nesting depth beyond limit");

endmodule
`default_nettype wire

// ----- rtl/core/bms_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bms_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module bms_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 127
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/bms_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bms_front
// byte history, quote and comment tracking, offset count, byte classing
// ----------------------------------------------------------------------------
module bms_front
    import bms_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_beat,
    input  wire logic       i_skip_qc,
    input  wire logic       i_start_scan,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_buffer,
    output      t_item      o_item
);

    logic [7:0]          r_prev, n_prev;
    logic [7:0]          r_pprev, n_pprev;
    logic                r_in_quote, n_in_quote;
    logic                r_quote_kind, n_quote_kind;
    logic                r_in_comment, n_in_comment;
    logic [OFFSET_W-1:0] r_count, n_count;

    logic [7:0]          old_c, older_c, quote_c;
    logic                in_quote_e, quote_kind_e, in_comment_e, skip;
    logic [OFFSET_W-1:0] count_e;

    always_comb begin
        old_c        = i_start_scan ? CH_NEWLINE : r_prev;
        older_c      = i_start_scan ? CH_NEWLINE : r_pprev;
        in_quote_e   = i_start_scan ? 1'b0 : r_in_quote;
        quote_kind_e = i_start_scan ? 1'b0 : r_quote_kind;
        in_comment_e = i_start_scan ? 1'b0 : r_in_comment;
        count_e      = i_start_scan ? '0 : r_count;
        quote_c      = quote_kind_e ? CH_SQUOTE : CH_DQUOTE;

        n_in_quote   = in_quote_e;
        n_quote_kind = quote_kind_e;
        n_in_comment = in_comment_e;
        skip         = 1'b0;

        if (i_skip_qc) begin
            if (in_quote_e) begin
                // a doubled backslash does not escape the quote
                if (i_text_byte == quote_c && (old_c != CH_BSLASH || older_c == CH_BSLASH)) begin
                    n_in_quote = 1'b0;
                end
                skip = 1'b1;
            end else if (in_comment_e) begin
                if (i_text_byte == CH_SLASH && old_c == CH_STAR) begin
                    n_in_comment = 1'b0;
                end
                skip = 1'b1;
            end else if ((i_text_byte == CH_DQUOTE || i_text_byte == CH_SQUOTE)
                         && old_c != CH_BSLASH) begin
                n_in_quote   = 1'b1;
                n_quote_kind = (i_text_byte == CH_SQUOTE);
                skip         = 1'b1;
            end else if (i_text_byte == CH_STAR && old_c == CH_SLASH) begin
                n_in_comment = 1'b1;
                skip         = 1'b1;
            end
        end

        n_prev  = i_text_byte;
        n_pprev = old_c;
        n_count = (count_e < COUNT_MAX) ? count_e + 1'b1 : count_e;

        o_item.start = i_start_scan;
        o_item.push  = skip ? CODE_NONE : push_code(i_text_byte);
        o_item.close = skip ? CODE_NONE : close_code(i_text_byte);
        o_item.eob   = i_end_of_buffer;
        o_item.here  = count_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= CH_NEWLINE;
            r_pprev      <= CH_NEWLINE;
            r_in_quote   <= 1'b0;
            r_quote_kind <= 1'b0;
            r_in_comment <= 1'b0;
            r_count      <= '0;
        end else if (i_beat) begin
            r_prev       <= n_prev;
            r_pprev      <= n_pprev;
            r_in_quote   <= n_in_quote;
            r_quote_kind <= n_quote_kind;
            r_in_comment <= n_in_comment;
            r_count      <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bms_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bms_queue
// two entry queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module bms_queue
    import bms_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_item i_item,
    input  wire logic i_pop,
    output      t_item o_item,
    output      t_q_status o_status
);

    t_item      r_slot [2];
    logic       r_head, n_head;
    logic       r_tail, n_tail;
    logic [1:0] r_fill, n_fill;

    always_comb begin
        n_head = i_pop  ? ~r_head : r_head;
        n_tail = i_push ? ~r_tail : r_tail;
        n_fill = r_fill + {1'b0, i_push} - {1'b0, i_pop};
        o_item         = r_slot[r_head];
        o_status.full  = (r_fill == 2'd2);
        o_status.valid = (r_fill != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_tail <= 1'b0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_tail] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/bms_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bms_back
// closer stack with cached top, depth count, scan decision, result register
// ----------------------------------------------------------------------------
module bms_back
    import bms_pkg::*;
#(
    parameter int DEPTH_LIMIT = 127
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_q_status           i_q_status,
    input  wire t_item               i_item,
    output      logic                o_pop,
    output      logic                o_out_valid,
    input  wire logic                i_out_ready,
    output      logic [STATUS_W-1:0] o_scan_status,
    output      logic [OFFSET_W-1:0] o_match_offset,
    output      logic [DEPTH_W-1:0]  o_nesting_depth
);

    localparam int RAM_AW = $clog2(DEPTH_LIMIT);
    localparam logic [DEPTH_W-1:0] LIMIT = DEPTH_W'(DEPTH_LIMIT);

    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic                r_done, n_done;
    logic [1:0]          r_top, n_top;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic                r_byp;
    logic [1:0]          r_byp_data;

    logic [DEPTH_W-1:0]  depth_e, wr_full, rd_full;
    logic                done_e, wr_en;
    logic [RAM_AW-1:0]   wr_addr, rd_addr;
    logic [1:0]          ram_rdata, second;

    always_comb begin
        o_pop   = i_q_status.valid && (!r_out_valid || i_out_ready);
        depth_e = i_item.start ? '0 : r_depth;
        done_e  = i_item.start ? 1'b0 : r_done;
        second  = r_byp ? r_byp_data : ram_rdata;

        n_depth  = r_depth;
        n_done   = r_done;
        n_top    = r_top;
        n_status = r_status;
        n_offset = r_offset;
        wr_en    = 1'b0;
        wr_full  = depth_e - 1'b1;

        if (o_pop) begin
            n_depth  = depth_e;
            n_done   = done_e;
            n_status = ST_SCANNING;
            n_offset = '0;
            if (!done_e) begin
                if (i_item.push != CODE_NONE) begin
                    // old top spills to ram below the new top
                    wr_en   = (depth_e != '0);
                    n_top   = i_item.push;
                    n_depth = depth_e + 1'b1;
                    if (n_depth >= LIMIT) begin
                        n_status = ST_OVERFLOW;
                    end
                end else if (i_item.close != CODE_NONE && depth_e != '0) begin
                    n_depth = depth_e - 1'b1;
                    n_top   = second;
                    if (r_top != i_item.close) begin
                        n_status = ST_MISMATCH;
                        n_offset = i_item.here;
                    end else if (n_depth == '0) begin
                        n_status = ST_MATCHED;
                        n_offset = i_item.here;
                    end
                end
                if (n_status == ST_SCANNING && i_item.eob) begin
                    n_status = ST_NOTFOUND;
                end
                n_done = (n_status != ST_SCANNING);
            end
        end

        // prefetch the entry under the next top
        rd_full = n_depth - 2'd2;
        wr_addr = wr_full[RAM_AW-1:0];
        rd_addr = rd_full[RAM_AW-1:0];

        n_out_valid = o_pop || (r_out_valid && !i_out_ready);
    end

    bms_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH_LIMIT)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (r_top),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            r_depth     <= n_depth;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            r_byp       <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_status   <= n_status;
        r_offset   <= n_offset;
        r_byp_data <= r_top;
    end

    assign o_out_valid     = r_out_valid;
    assign o_scan_status   = r_status;
    assign o_match_offset  = r_offset;
    assign o_nesting_depth = r_depth;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bracket match scanner: a predictor in a small
// scoreboard mirrors the scan state, random bracket text with quotes, escapes
// and comments is streamed in with random idling on both channels, and each
// result beat is compared field by field with the predicted one
// ----------------------------------------------------------------------------
import bms_pkg::*;

class bracket_scoreboard #(int STACK_DEPTH = 128);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] offset;
        logic [DEPTH_W-1:0]  depth;
    } scan_result_t;

    bit                  skip_mode;
    logic [7:0]          last_ch;
    logic [7:0]          last2_ch;
    bit                  in_quote;
    bit                  single_quote;
    bit                  in_comment;
    int                  depth;
    int                  depth_limit;
    logic [1:0]          closers [STACK_DEPTH];
    logic [OFFSET_W-1:0] byte_count;
    bit                  done;
    int                  errors;
    int                  status_seen [5];
    scan_result_t        results_due [$];

    function new();
        skip_mode   = 1'b1;
        depth_limit = (STACK_DEPTH - 1 < 127) ? STACK_DEPTH - 1 : 127;
        errors      = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        clear_scan();
    endfunction

    function void clear_scan();
        last_ch      = CH_NEWLINE;
        last2_ch     = CH_NEWLINE;
        in_quote     = 1'b0;
        single_quote = 1'b0;
        in_comment   = 1'b0;
        depth        = 0;
        byte_count   = '0;
        done         = 1'b0;
    endfunction

    function void set_skip(bit v);
        skip_mode = v;
    endfunction

    function int pending();
        return results_due.size();
    endfunction

    // predict the result of one accepted input beat
    function void note_byte(logic start, logic [7:0] ch, logic eob);
        scan_result_t        r;
        logic [7:0]          old_ch;
        logic [7:0]          older_ch;
        logic [7:0]          quote_ch;
        logic [1:0]          push;
        logic [1:0]          close;
        logic [1:0]          top;
        logic [OFFSET_W-1:0] here;
        bit                  skip;

        r.status = ST_SCANNING;
        r.offset = '0;
        if (start)
            clear_scan();
        if (!done) begin
            here = byte_count;
            if (byte_count != COUNT_MAX)
                byte_count++;
            old_ch   = last_ch;
            older_ch = last2_ch;
            last2_ch = last_ch;
            last_ch  = ch;
            skip     = 1'b0;

            if (skip_mode) begin
                quote_ch = single_quote ? CH_SQUOTE : CH_DQUOTE;
                if (in_quote) begin
                    // an escaped quote stays inside, a double backslash does not escape
                    if (ch == quote_ch && (old_ch != CH_BSLASH || older_ch == CH_BSLASH))
                        in_quote = 1'b0;
                    skip = 1'b1;
                end else if (in_comment) begin
                    if (ch == CH_SLASH && old_ch == CH_STAR)
                        in_comment = 1'b0;
                    skip = 1'b1;
                end else if ((ch == CH_DQUOTE || ch == CH_SQUOTE) && old_ch != CH_BSLASH) begin
                    in_quote     = 1'b1;
                    single_quote = (ch == CH_SQUOTE);
                    skip         = 1'b1;
                end else if (ch == CH_STAR && old_ch == CH_SLASH) begin
                    in_comment = 1'b1;
                    skip       = 1'b1;
                end
            end

            if (!skip) begin
                case (ch)
                    CH_LBRACE:   push = CODE_BRACE;
                    CH_LPAREN:   push = CODE_PAREN;
                    CH_LBRACKET: push = CODE_BRACKET;
                    default:     push = CODE_NONE;
                endcase
                case (ch)
                    CH_RBRACE:   close = CODE_BRACE;
                    CH_RPAREN:   close = CODE_PAREN;
                    CH_RBRACKET: close = CODE_BRACKET;
                    default:     close = CODE_NONE;
                endcase
                if (push != CODE_NONE) begin
                    if (depth < STACK_DEPTH)
                        closers[depth] = push;
                    depth++;
                    if (depth >= depth_limit)
                        r.status = ST_OVERFLOW;
                end else if (close != CODE_NONE && depth > 0) begin
                    depth--;
                    top = (depth < STACK_DEPTH) ? closers[depth] : CODE_NONE;
                    if (top != close) begin
                        r.status = ST_MISMATCH;
                        r.offset = here;
                    end else if (depth == 0) begin
                        r.status = ST_MATCHED;
                        r.offset = here;
                    end
                end
            end

            if (r.status == ST_SCANNING && eob)
                r.status = ST_NOTFOUND;
            if (r.status != ST_SCANNING)
                done = 1'b1;
        end
        r.depth = depth[DEPTH_W-1:0];
        results_due.push_back(r);
    endfunction

    // compare one accepted result beat with the oldest prediction
    function void check_result(logic [STATUS_W-1:0] st, logic [OFFSET_W-1:0] off,
                               logic [DEPTH_W-1:0] dep);
        scan_result_t want;

        if (results_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, status %0d offset %0d depth %0d",
                     $time, st, off, dep);
            return;
        end
        want = results_due.pop_front();
        status_seen[want.status]++;
        if (st !== want.status) begin
            errors++;
            $display("%0t: scan_status expected %0d got %0d", $time, want.status, st);
        end
        if (off !== want.offset) begin
            errors++;
            $display("%0t: match_offset expected %0d got %0d", $time, want.offset, off);
        end
        if (dep !== want.depth) begin
            errors++;
            $display("%0t: nesting_depth expected %0d got %0d", $time, want.depth, dep);
        end
    endfunction

endclass

module tb_top;

    localparam int STACK_DEPTH = 128;
    localparam int ITEMS       = 1700;
    localparam int PHASES      = 4;

    // clock, reset and the three channels
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic                start_scan    = 1'b0;
    logic [7:0]          text_byte     = 8'h00;
    logic                end_of_buffer = 1'b0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [STATUS_W-1:0] scan_status;
    logic [OFFSET_W-1:0] match_offset;
    logic [DEPTH_W-1:0]  nesting_depth;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic                cfg_data      = 1'b1;

    bracket_scoreboard #(STACK_DEPTH) sb;

    // run bookkeeping
    int         beats_sent    = 0;
    int         scans_started = 0;
    int         in_calm       = 0;
    int         out_calm      = 0;
    logic [7:0] scan_text [$];

    bracket_match_scanner #(
        .STACK_DEPTH     (STACK_DEPTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_start_scan    (start_scan),
        .i_text_byte     (text_byte),
        .i_end_of_buffer (end_of_buffer),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_scan_status   (scan_status),
        .o_match_offset  (match_offset),
        .o_nesting_depth (nesting_depth),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // random idle cycles before a beat, with calm stretches of no idling now and then
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // kind 0 brace, 1 paren, 2 bracket
    function automatic logic [7:0] bracket_char(int kind, bit closing);
        case (kind)
            0:       return closing ? CH_RBRACE : CH_LBRACE;
            1:       return closing ? CH_RPAREN : CH_LPAREN;
            default: return closing ? CH_RBRACKET : CH_LBRACKET;
        endcase
    endfunction

    // filler byte, biased towards the characters the scanner reacts to
    function automatic logic [7:0] noise_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return bracket_char($urandom_range(0, 2), 1'b0);
        if (r < 24) return bracket_char($urandom_range(0, 2), 1'b1);
        if (r < 30) return $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        if (r < 35) return CH_BSLASH;
        if (r < 40) return CH_STAR;
        if (r < 45) return CH_SLASH;
        if (r < 50) return CH_NEWLINE;
        return 8'($urandom_range(0, 255));
    endfunction

    // one input beat; valid stays high across back-to-back beats
    task automatic send_beat(input logic s, input logic [7:0] ch, input logic eob);
        int gap;
        gap = draw_wait(in_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        start_scan    <= s;
        text_byte     <= ch;
        end_of_buffer <= eob;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_byte(s, ch, eob);
        beats_sent++;
    endtask

    task automatic send_string(input string s, input bit eob_last);
        for (int i = 0; i < s.len(); i++)
            send_beat(i == 0, s[i], eob_last && i == s.len() - 1);
    endtask

    // stop sending and let every predicted result come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // the register is only written while the scanner is idle
    task automatic write_skip_mode(input bit v);
        drain_results();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_skip(v);
    endtask

    // a mostly well-formed scan: nested brackets with comments, quotes and escapes
    // in between, now and then a wrong closer; may run out before it closes
    task automatic send_bracket_scan(input int max_len);
        int         kinds [$];
        int         k;
        int         n;
        int         r;
        int         c;
        logic [7:0] q;
        bit         eob_at_end;
        bit         fresh;

        scan_text.delete();
        k = $urandom_range(0, 2);
        scan_text.push_back(bracket_char(k, 1'b0));
        kinds.push_back(k);
        while (kinds.size() > 0 && scan_text.size() < max_len) begin
            r = $urandom_range(0, 99);
            if (r < 28) begin
                k = $urandom_range(0, 2);
                scan_text.push_back(bracket_char(k, 1'b0));
                kinds.push_back(k);
            end else if (r < 58) begin
                scan_text.push_back(bracket_char(kinds.pop_back(), 1'b1));
            end else if (r < 61) begin
                // wrong closer
                k = (kinds.pop_back() + $urandom_range(1, 2)) % 3;
                scan_text.push_back(bracket_char(k, 1'b1));
            end else if (r < 68) begin
                // block comment, possibly with brackets and stars inside
                scan_text.push_back(CH_SLASH);
                scan_text.push_back(CH_STAR);
                n = $urandom_range(0, 4);
                repeat (n) scan_text.push_back(noise_char());
                scan_text.push_back(CH_STAR);
                scan_text.push_back(CH_SLASH);
            end else if (r < 76) begin
                // quoted text with escaped quotes and double backslashes
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                scan_text.push_back(q);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    c = $urandom_range(0, 5);
                    if (c == 0) begin
                        scan_text.push_back(CH_BSLASH);
                        scan_text.push_back(q);
                    end else if (c == 1) begin
                        scan_text.push_back(CH_BSLASH);
                        scan_text.push_back(CH_BSLASH);
                    end else begin
                        scan_text.push_back(noise_char());
                    end
                end
                scan_text.push_back(q);
            end else begin
                scan_text.push_back(noise_char());
            end
        end
        eob_at_end = ($urandom_range(0, 3) != 0);
        fresh      = ($urandom_range(0, 19) != 0);
        scans_started++;
        foreach (scan_text[i])
            send_beat((i == 0) && fresh, scan_text[i],
                      eob_at_end && i == scan_text.size() - 1);
    endtask

    // result side: random stalls, every accepted beat checked
    initial begin
        int stall;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            stall = draw_wait(out_calm);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_result(scan_status, match_offset, nesting_depth);
        end
    end

    // stimulus
    initial begin
        int phase;
        int target;
        int r;
        int n;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // phases alternate skipping on and plain matching
        for (phase = 0; phase < PHASES; phase++) begin
            write_skip_mode(phase % 2 == 0);

            if (phase == 0) begin
                // all three kinds nested, end flag on the matching byte
                send_string("{([])}", 1'b1);
                // paren closed by a bracket
                send_string("(]", 1'b0);
                // byte extremes, closer on an empty stack, end of buffer
                send_beat(1'b1, 8'h00, 1'b0);
                send_beat(1'b0, CH_RPAREN, 1'b0);
                send_beat(1'b0, 8'hFF, 1'b1);
                // escaped quote stays quoted, double backslash then quote ends it
                send_string("(\")\\\"\\\\\")", 1'b1);
                // comment closed by the slash right after its opening star
                send_string("(/*/)", 1'b1);
            end

            target = ITEMS * (phase + 1) / PHASES;
            while (beats_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    // run of openers around the depth limit
                    n = $urandom_range(124, 130);
                    scans_started++;
                    for (int i = 0; i < n; i++)
                        send_beat(i == 0, bracket_char($urandom_range(0, 2), 1'b0),
                                  (i == n - 1) && $urandom_range(0, 1));
                end else if (r < 85) begin
                    send_bracket_scan($urandom_range(2, 40));
                end else begin
                    // loose bytes with random start and end flags
                    n = $urandom_range(1, 8);
                    repeat (n)
                        send_beat($urandom_range(0, 9) == 0, noise_char(),
                                  $urandom_range(0, 9) == 0);
                end
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
        end

        drain_results();

        $display("covered %0d input beats in %0d scans, skipping on and off",
                 beats_sent, scans_started);
        $display("results: %0d scanning, %0d matched, %0d mismatch, %0d not found, %0d overflow",
                 sb.status_seen[ST_SCANNING], sb.status_seen[ST_MATCHED],
                 sb.status_seen[ST_MISMATCH], sb.status_seen[ST_NOTFOUND],
                 sb.status_seen[ST_OVERFLOW]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
